// ----- rtl/cfa_pkg.sv -----
// Package with the shared constants and codes of the contiguous fit allocator.
package cfa_pkg;

    localparam int unsigned DEF_NUM_UNITS = 4096;
    localparam int unsigned MAX_NUM_UNITS = 262144;

    localparam int unsigned CMD_W    = 2;
    localparam int unsigned SIZE_W   = 13;
    localparam int unsigned REGION_W = 12;
    localparam int unsigned ADDR_O_W = 12;
    localparam int unsigned USED_O_W = 13;
    localparam int unsigned POLICY_W = 2;

    localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPACT = 2'd2;

    localparam logic [POLICY_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POL_WORST = 2'd2;

endpackage

// ----- rtl/contiguous_fit_allocator_top.sv -----
// Top level of the contiguous fit allocator: occupancy memory and its sequencer.
//
// Usage: drive i_cmd, i_alloc_size, i_region_start and i_region_end and raise
// start; the command is taken at a clock edge with start high and busy low.
// busy stays high while the command works through the occupancy memory, one
// unit per cycle. The result (o_ok, o_alloc_start, o_alloc_end, o_used_units)
// is shown for exactly one cycle with o_done high, and busy is low in that
// cycle, so the next command may be taken right away. There is no result
// back-pressure; a receiver must take o_done when it comes.
// An allocate scans the map and then marks the units that it picks (first
// fit stops at the first hole that fits). A release reads and clears its
// region, a compact rewrites the whole map. A bad size, a bad region or an
// unknown command completes without touching the map, which has a single
// read and a single write port. The fit policy register is written through
// i_cfg_valid / o_cfg_ready; the user must write it only while the block is
// idle, which the block itself does not enforce. After reset a clearing pass
// zeroes the map; busy is high during it. The policy resets to first fit.
module contiguous_fit_allocator_top #(
    parameter int unsigned NUM_UNITS = cfa_pkg::DEF_NUM_UNITS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [cfa_pkg::CMD_W-1:0]        i_cmd,
    input  logic [cfa_pkg::SIZE_W-1:0]       i_alloc_size,
    input  logic [cfa_pkg::REGION_W-1:0]     i_region_start,
    input  logic [cfa_pkg::REGION_W-1:0]     i_region_end,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [cfa_pkg::POLICY_W-1:0]     i_cfg_fit_policy,
    output logic                             o_done,
    output logic                             o_ok,
    output logic [cfa_pkg::ADDR_O_W-1:0]     o_alloc_start,
    output logic [cfa_pkg::ADDR_O_W-1:0]     o_alloc_end,
    output logic [cfa_pkg::USED_O_W-1:0]     o_used_units
);

    localparam int unsigned AW = $clog2(NUM_UNITS);
    localparam int unsigned CW = $clog2(NUM_UNITS + 1);
    localparam int unsigned LW = (CW > cfa_pkg::SIZE_W) ? CW : cfa_pkg::SIZE_W;
    localparam int unsigned XW = (LW > cfa_pkg::ADDR_O_W) ? LW : cfa_pkg::ADDR_O_W;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_MARK  = 3'd3;
    localparam logic [2:0] ST_REL   = 3'd4;
    localparam logic [2:0] ST_COMP  = 3'd5;

    localparam logic [AW:0]   LAST_IDX = (AW+1)'(NUM_UNITS - 1);
    localparam logic [LW-1:0] NUM_L    = LW'(NUM_UNITS);

    // Occupancy memory, one bit per unit.
    logic r_mem [NUM_UNITS];
    logic r_rd_data;

    logic [2:0]                    r_state, n_state;
    logic [AW:0]                   r_idx, n_idx;
    logic [AW:0]                   r_lim, n_lim;
    logic                          r_pv, n_pv;
    logic [AW-1:0]                 r_pi, n_pi;
    logic [LW-1:0]                 r_size, n_size;
    logic [LW-1:0]                 r_used, n_used;
    logic [LW-1:0]                 r_run_len, n_run_len;
    logic [AW-1:0]                 r_run_first, n_run_first;
    logic                          r_found, n_found;
    logic [LW-1:0]                 r_pick_len, n_pick_len;
    logic [AW-1:0]                 r_pick_first, n_pick_first;
    logic [LW-1:0]                 r_cnt, n_cnt;
    logic [cfa_pkg::POLICY_W-1:0]  r_policy;
    logic                          r_done, n_done;
    logic                          r_ok, n_ok;
    logic [cfa_pkg::ADDR_O_W-1:0]  r_astart, n_astart;
    logic [cfa_pkg::ADDR_O_W-1:0]  r_aend, n_aend;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          wr_data;

    logic          accept;
    logic          is_free;
    logic          is_last;
    logic          closing;
    logic          fits;
    logic          take;
    logic [LW-1:0] eff_len;
    logic [AW-1:0] eff_first;
    logic [LW-1:0] req_size;
    logic [LW-1:0] rel_end;
    logic [XW-1:0] x_start;
    logic [XW-1:0] x_end;

    assign accept      = start && !busy;
    assign busy        = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    // Run tracking for the pending unit of the scan.
    assign is_free   = !r_rd_data;
    assign is_last   = ({1'b0, r_pi} == LAST_IDX);
    assign eff_len   = is_free ? (r_run_len + LW'(1)) : r_run_len;
    assign eff_first = (is_free && (r_run_len == '0)) ? r_pi : r_run_first;
    assign closing   = !is_free || is_last;
    assign fits      = (eff_len != '0) && (eff_len >= r_size);
    assign req_size  = LW'(i_alloc_size);
    assign rel_end   = LW'(i_region_end);
    assign x_start   = XW'(r_pick_first);
    assign x_end     = XW'(r_pick_first) + XW'(r_size) - XW'(1);

    always_comb begin
        unique case (r_policy)
            cfa_pkg::POL_BEST:  take = closing && fits && (!r_found || eff_len <= r_pick_len);
            cfa_pkg::POL_WORST: take = closing && fits && (!r_found || eff_len >= r_pick_len);
            default:            take = closing && fits;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_lim        = r_lim;
        n_pv         = 1'b0;
        n_pi         = r_idx[AW-1:0];
        n_size       = r_size;
        n_used       = r_used;
        n_run_len    = r_run_len;
        n_run_first  = r_run_first;
        n_found      = r_found;
        n_pick_len   = r_pick_len;
        n_pick_first = r_pick_first;
        n_cnt        = r_cnt;
        n_done       = 1'b0;
        n_ok         = r_ok;
        n_astart     = r_astart;
        n_aend       = r_aend;
        rd_en        = 1'b0;
        rd_addr      = r_idx[AW-1:0];
        wr_en        = 1'b0;
        wr_addr      = r_idx[AW-1:0];
        wr_data      = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                wr_en = 1'b1;
                n_idx = r_idx + (AW+1)'(1);
                if (r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    n_idx       = '0;
                    n_size      = req_size;
                    n_run_len   = '0;
                    n_run_first = '0;
                    n_found     = 1'b0;
                    n_pick_len  = '0;
                    n_astart    = '0;
                    n_aend      = '0;
                    n_ok        = 1'b0;
                    n_done      = 1'b1;
                    priority if (i_cmd == cfa_pkg::CMD_ALLOC) begin
                        if (req_size != '0 && req_size <= NUM_L) begin
                            n_state = ST_SCAN;
                            n_lim   = LAST_IDX;
                            n_done  = 1'b0;
                        end
                    end else if (i_cmd == cfa_pkg::CMD_RELEASE) begin
                        if (i_region_start <= i_region_end && rel_end < NUM_L) begin
                            n_state = ST_REL;
                            n_idx   = (AW+1)'(i_region_start);
                            n_lim   = (AW+1)'(i_region_end);
                            n_done  = 1'b0;
                        end
                    end else if (i_cmd == cfa_pkg::CMD_COMPACT) begin
                        n_state = ST_COMP;
                        n_done  = 1'b0;
                    end else begin
                        n_ok = 1'b0;
                    end
                end
            end
            ST_SCAN: begin
                if (r_idx <= r_lim) begin
                    rd_en = 1'b1;
                    n_pv  = 1'b1;
                    n_idx = r_idx + (AW+1)'(1);
                end
                if (r_pv) begin
                    n_run_len   = closing ? '0 : eff_len;
                    n_run_first = eff_first;
                    if (take) begin
                        n_found      = 1'b1;
                        n_pick_len   = eff_len;
                        n_pick_first = eff_first;
                    end
                    // First fit stops at the first hole; the others finish the map.
                    if ((take && r_policy != cfa_pkg::POL_BEST
                              && r_policy != cfa_pkg::POL_WORST)
                        || (is_last && (take || r_found))) begin
                        n_state = ST_MARK;
                        n_pv    = 1'b0;
                        n_idx   = (AW+1)'(take ? eff_first : r_pick_first);
                        n_cnt   = r_size;
                        if (take) begin
                            n_pick_first = eff_first;
                        end
                    end else if (is_last) begin
                        n_state = ST_IDLE;
                        n_pv    = 1'b0;
                        n_done  = 1'b1;
                    end
                end
            end
            ST_MARK: begin
                wr_en   = 1'b1;
                wr_data = 1'b1;
                n_idx   = r_idx + (AW+1)'(1);
                n_cnt   = r_cnt - LW'(1);
                if (r_cnt == LW'(1)) begin
                    n_state  = ST_IDLE;
                    n_used   = r_used + r_size;
                    n_ok     = 1'b1;
                    n_astart = x_start[cfa_pkg::ADDR_O_W-1:0];
                    n_aend   = x_end[cfa_pkg::ADDR_O_W-1:0];
                    n_done   = 1'b1;
                end
            end
            ST_REL: begin
                if (r_idx <= r_lim) begin
                    rd_en = 1'b1;
                    n_pv  = 1'b1;
                    n_idx = r_idx + (AW+1)'(1);
                end
                // Reads run strictly ahead of the write, so no entry is read stale.
                if (r_pv) begin
                    wr_addr = r_pi;
                    if (r_rd_data) begin
                        wr_en  = 1'b1;
                        n_used = r_used - LW'(1);
                    end
                    if ({1'b0, r_pi} == r_lim) begin
                        n_state = ST_IDLE;
                        n_pv    = 1'b0;
                        n_ok    = 1'b1;
                        n_done  = 1'b1;
                    end
                end
            end
            ST_COMP: begin
                wr_en   = 1'b1;
                wr_data = (LW'(r_idx) < r_used);
                n_idx   = r_idx + (AW+1)'(1);
                if (r_idx == LAST_IDX) begin
                    n_state = ST_IDLE;
                    n_ok    = 1'b1;
                    n_done  = 1'b1;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_idx    <= '0;
            r_pv     <= 1'b0;
            r_used   <= '0;
            r_found  <= 1'b0;
            r_done   <= 1'b0;
            r_policy <= cfa_pkg::POL_FIRST;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pv    <= n_pv;
            r_used  <= n_used;
            r_found <= n_found;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_policy <= i_cfg_fit_policy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_lim        <= n_lim;
        r_pi         <= n_pi;
        r_size       <= n_size;
        r_run_len    <= n_run_len;
        r_run_first  <= n_run_first;
        r_pick_len   <= n_pick_len;
        r_pick_first <= n_pick_first;
        r_cnt        <= n_cnt;
        r_ok         <= n_ok;
        r_astart     <= n_astart;
        r_aend       <= n_aend;
    end

    assign o_done        = r_done;
    assign o_ok          = r_ok;
    assign o_alloc_start = r_astart;
    assign o_alloc_end   = r_aend;
    assign o_used_units  = r_used[cfa_pkg::USED_O_W-1:0];

`ifndef SYNTH
    a_done_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while a command is still running");

    a_fail_zero_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_ok) |-> (o_alloc_start == '0 && o_alloc_end == '0))
        else $error("failed command reports a nonzero range");

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= NUM_L)
        else $error("used unit count exceeds the map size");

    a_accept_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted command neither ran nor completed");
`endif

endmodule
